FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define TPT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tpt assertion failed");

// property checked at every rising edge, reset included
`define TPT_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpt assertion failed");

`endif

FILE: rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// ntc table, segment constants and shared types for the temperature unit
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  localparam int unsigned NTC_POINTS  = 20;
  localparam int unsigned STEP_CENTI  = 500;
  localparam logic [13:0] ERROR_CENTI = 14'd10000;
  localparam logic [13:0] MAX_CENTI   = 14'd9500;
  localparam int unsigned RECIP_SHIFT = 31;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_VALID  = 2'd0;
  localparam logic [1:0] REG_SECOND_VALID = 2'd1;
  localparam logic [1:0] REG_OPEN_MV      = 2'd2;

  // thermistor to nominal resistance ratio, units of 1e-5, 0 to 95 C in 5 C steps
  localparam int unsigned RATIO [20] = '{
    326500, 253900, 199000, 157100, 124900,
    100000,  80570,  65310,  53270,  43690,
     36030,  29860,  24880,  20830,  17520,
     14810,  12580,  10720,   9177,   7885
  };

  // floor(2^31 / (33 * (ratio[i-1] - ratio[i]))), entry 0 unused
  localparam logic [15:0] RECIP [20] = '{
    16'd0,
    16'((64'd1 << 31) / (33 * (326500 - 253900))),
    16'((64'd1 << 31) / (33 * (253900 - 199000))),
    16'((64'd1 << 31) / (33 * (199000 - 157100))),
    16'((64'd1 << 31) / (33 * (157100 - 124900))),
    16'((64'd1 << 31) / (33 * (124900 - 100000))),
    16'((64'd1 << 31) / (33 * (100000 -  80570))),
    16'((64'd1 << 31) / (33 * ( 80570 -  65310))),
    16'((64'd1 << 31) / (33 * ( 65310 -  53270))),
    16'((64'd1 << 31) / (33 * ( 53270 -  43690))),
    16'((64'd1 << 31) / (33 * ( 43690 -  36030))),
    16'((64'd1 << 31) / (33 * ( 36030 -  29860))),
    16'((64'd1 << 31) / (33 * ( 29860 -  24880))),
    16'((64'd1 << 31) / (33 * ( 24880 -  20830))),
    16'((64'd1 << 31) / (33 * ( 20830 -  17520))),
    16'((64'd1 << 31) / (33 * ( 17520 -  14810))),
    16'((64'd1 << 31) / (33 * ( 14810 -  12580))),
    16'((64'd1 << 31) / (33 * ( 12580 -  10720))),
    16'((64'd1 << 31) / (33 * ( 10720 -   9177))),
    16'((64'd1 << 31) / (33 * (  9177 -   7885)))
  };

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNCAL = 2'd1,
    STAT_OPEN  = 2'd2
  } status_t;

  // result of the front stage
  typedef struct packed {
    status_t     status;
    logic        bypass;  // value holds the final temperature
    logic [13:0] value;
    logic [4:0]  seg;     // table segment, 1..19
    logic [30:0] y;       // rounded-up numerator of the interpolation
  } front_t;

  // result of the reciprocal multiply
  typedef struct packed {
    front_t     f;
    logic [9:0] q0;       // quotient estimate, low by at most one
  } quot_t;

  // smallest millivolt sum at or above entry i: ceil(ratio * 33 / 1000)
  function automatic logic [13:0] seg_threshold(input logic [4:0] i);
    return 14'((RATIO[i] * 33 + 999) / 1000);
  endfunction

  // ratio of entry i scaled to the millivolt sum times 1000
  function automatic logic [23:0] seg_offset(input logic [4:0] i);
    return 24'(RATIO[i] * 33);
  endfunction

  // span of segment i on the same scale
  function automatic logic [21:0] seg_den(input logic [4:0] i);
    return 22'(33 * (RATIO[i - 5'd1] - RATIO[i]));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tpt_front.sv
// ----------------------------------------------------------------------------
// tpt_front
// error checks, table segment search and interpolation numerator
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_front (
  input  wire logic [11:0]     first_mv,
  input  wire logic [11:0]     second_mv,
  input  wire logic            first_valid,
  input  wire logic            second_valid,
  input  wire logic [11:0]     open_mv,
  output tpt_pkg::front_t      f
);

  logic [12:0] sum_mv;
  logic [19:1] ge;
  logic [4:0]  seg;
  logic [23:0] n_wide;
  logic [21:0] n;
  logic [21:0] den;

  assign sum_mv = 13'(first_mv) + 13'(second_mv);

  // thermometer of sum >= entry, then the first entry that is reached
  always_comb begin
    for (int i = 1; i < 20; i++) begin
      ge[i] = {1'b0, sum_mv} >= tpt_pkg::seg_threshold(5'(i));
    end
    seg = 5'd19;
    for (int i = 19; i >= 1; i--) begin
      if (ge[i]) begin
        seg = 5'(i);
      end
    end
  end

  assign n_wide = 24'(sum_mv) * 24'd1000 - tpt_pkg::seg_offset(seg);
  assign n      = n_wide[21:0];
  assign den    = tpt_pkg::seg_den(seg);

  always_comb begin
    f.seg    = seg;
    f.y      = 31'(n) * 31'd500 + 31'(den) - 31'd1;
    f.bypass = 1'b1;
    f.value  = tpt_pkg::ERROR_CENTI;
    f.status = tpt_pkg::STAT_OK;
    if (!first_valid || !second_valid) begin
      f.status = tpt_pkg::STAT_UNCAL;
    end else if (first_mv >= open_mv || second_mv >= open_mv) begin
      f.status = tpt_pkg::STAT_OPEN;
    end else if ({1'b0, sum_mv} >= tpt_pkg::seg_threshold(5'd0)) begin
      f.value = 14'd0;
    end else if (!ge[19]) begin
      f.value = tpt_pkg::MAX_CENTI;
    end else begin
      f.bypass = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpt_quot.sv
// ----------------------------------------------------------------------------
// tpt_quot
// quotient estimate by multiplying with the segment reciprocal
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_quot (
  input  wire tpt_pkg::front_t f,
  output tpt_pkg::quot_t       q
);

  logic [46:0] prod;

  assign prod = 47'(f.y) * 47'(tpt_pkg::RECIP[f.seg]);

  always_comb begin
    q.f  = f;
    q.q0 = prod[tpt_pkg::RECIP_SHIFT +: 10];
  end

endmodule

`default_nettype wire

FILE: rtl/tpt_fix.sv
// ----------------------------------------------------------------------------
// tpt_fix
// one-step quotient correction and final temperature
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_fix (
  input  wire tpt_pkg::quot_t  q,
  output logic [13:0]          temp_centi,
  output tpt_pkg::status_t     status
);

  logic [32:0] next_mult;
  logic        corr;
  logic [13:0] base;
  logic [13:0] x;

  // estimate is low by one when y still covers another full span
  assign next_mult = (33'(q.q0) + 33'd1) * 33'(tpt_pkg::seg_den(q.f.seg));
  assign corr      = 33'(q.f.y) >= next_mult;
  assign base      = 14'(q.f.seg) * 14'(tpt_pkg::STEP_CENTI);
  assign x         = 14'(q.q0) + 14'(corr);

  assign temp_centi = q.f.bypass ? q.f.value : base - x;
  assign status     = q.f.status;

endmodule

`default_nettype wire

FILE: rtl/thermistor_pair_to_temperature_unit.sv
// stages: four registers, input, front, quotient and output, lie between s_tdata and m_tvalid
// throughput: one word per cycle unless m_tready stalls; a stage passes on once the next frees
// the deepest path is the 31 x 16 reciprocal multiply between stage one and two
// reset (rst, synchronous): empties every stage, channels marked uncalibrated,
// open-sensor threshold back to 2450 mV
// ----------------------------------------------------------------------------
// thermistor_pair_to_temperature_unit
// two ntc divider voltages to a temperature in hundredths of a degree
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_pair_to_temperature_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,    // first_sample_mv [11:0], second_sample_mv [23:12]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,    // temperature_centi_c [13:0], zero [15:14]
  output logic [1:0]       m_tuser,    // status [1:0]
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  // configuration registers
  logic        first_valid;
  logic        second_valid;
  logic [11:0] open_mv;

  // stage valids
  logic v_in, v1, v2, v_out;
  logic rdy_out, rdy2, rdy1, rdy_in;

  // stage payloads
  logic [11:0]      first_mv;
  logic [11:0]      second_mv;
  tpt_pkg::front_t  front_d, front_q;
  tpt_pkg::quot_t   quot_d, quot_q;
  logic [13:0]      temp_d, temp_q;
  tpt_pkg::status_t status_d, status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid  <= 1'b0;
      second_valid <= 1'b0;
      open_mv      <= 12'd2450;
    end else if (cfg_we) begin
      case (cfg_index)
        tpt_pkg::REG_FIRST_VALID:  first_valid  <= cfg_data[0];
        tpt_pkg::REG_SECOND_VALID: second_valid <= cfg_data[0];
        tpt_pkg::REG_OPEN_MV:      open_mv      <= cfg_data;
        default: ;
      endcase
    end
  end

  // each stage moves on when it is empty or its successor moves on
  assign rdy_out  = !v_out || m_tready;
  assign rdy2     = !v2 || rdy_out;
  assign rdy1     = !v1 || rdy2;
  assign rdy_in   = !v_in || rdy1;
  assign s_tready = rdy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy_in)  v_in  <= s_tvalid;
      if (rdy1)    v1    <= v_in;
      if (rdy2)    v2    <= v1;
      if (rdy_out) v_out <= v2;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (rdy_in) begin
      first_mv  <= s_tdata[11:0];
      second_mv <= s_tdata[23:12];
    end
    if (rdy1) begin
      front_q <= front_d;
    end
    if (rdy2) begin
      quot_q <= quot_d;
    end
    if (rdy_out) begin
      temp_q   <= temp_d;
      status_q <= status_d;
    end
  end

  // checks, segment search and numerator
  tpt_front u_front (
    .first_mv     (first_mv),
    .second_mv    (second_mv),
    .first_valid  (first_valid),
    .second_valid (second_valid),
    .open_mv      (open_mv),
    .f            (front_d)
  );

  // reciprocal multiply
  tpt_quot u_quot (
    .f (front_q),
    .q (quot_d)
  );

  // correction and final subtract
  tpt_fix u_fix (
    .q          (quot_q),
    .temp_centi (temp_d),
    .status     (status_d)
  );

  assign m_tvalid = v_out;
  assign m_tdata  = {2'b00, temp_q};
  assign m_tuser  = status_q;

endmodule

`default_nettype wire

FILE: rtl/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker
// port-level checks on the temperature unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result word holds
  `TPT_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // any error status carries the fixed error temperature
  `TPT_ASSERT(a_err_temp, clk, rst, m_tvalid && m_tuser != tpt_pkg::STAT_OK |-> m_tdata[13:0] == tpt_pkg::ERROR_CENTI)

  // a good reading stays within the table span
  `TPT_ASSERT(a_ok_range, clk, rst, m_tvalid && m_tuser == tpt_pkg::STAT_OK |-> m_tdata[13:0] <= tpt_pkg::MAX_CENTI)

  // no status code beyond sensor open
  `TPT_ASSERT(a_status, clk, rst, m_tvalid |-> m_tuser <= tpt_pkg::STAT_OPEN)

  // the pipe is empty the cycle after reset
  `TPT_ASSERT_ALL(a_reset_empty, clk, $fell(rst) |-> !m_tvalid)

endmodule

bind thermistor_pair_to_temperature_unit tpt_checker u_tpt_checker (.*);

`default_nettype wire
